// ===== src/fce_pkg.sv =====
// ----------------------------------------------------------------------------
// fce_pkg
// Shared types, codes and the microcode program of the chain table engine.
// ----------------------------------------------------------------------------
package fce_pkg;

  // command codes
  localparam logic [2:0] CMD_ALLOC  = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_SEEK   = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_WRITE  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_LOOP = 2'd3;

  localparam logic [31:0] END_MARK = 32'hFFFF_FFFF;

  typedef logic [3:0] step_t;

  // program addresses
  localparam step_t STEP_IDLE        = 4'd0;
  localparam step_t STEP_DISPATCH    = 4'd1;
  localparam step_t STEP_ALLOC_START = 4'd2;
  localparam step_t STEP_SCAN        = 4'd3;
  localparam step_t STEP_SCAN_FOUND  = 4'd4;
  localparam step_t STEP_APPEND_LINK = 4'd5;
  localparam step_t STEP_EMIT_OK     = 4'd6;
  localparam step_t STEP_EMIT_ERR    = 4'd7;
  localparam step_t STEP_SEEK        = 4'd8;
  localparam step_t STEP_FIND_INIT   = 4'd9;
  localparam step_t STEP_FIND        = 4'd10;
  localparam step_t STEP_WRITE       = 4'd11;
  localparam step_t STEP_CLEAR       = 4'd12;

  typedef enum logic [3:0] {
    C_NEXT, C_JUMP, C_WAIT, C_CMD, C_SCAN,
    C_APPEND, C_SEEK, C_FIND, C_CLEAR, C_EMIT
  } cond_e;

  typedef enum logic [2:0] {A_CUR, A_CUR_INC, A_IDX, A_LINK, A_ONE} addr_e;
  typedef enum logic {W_CUR, W_IDX} waddr_e;
  typedef enum logic [1:0] {D_ZERO, D_END, D_VAL, D_CUR} wdata_e;
  typedef enum logic [2:0] {CUR_HOLD, CUR_IDX, CUR_ONE, CUR_INC, CUR_LINK} cur_op_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_ONE, CNT_INC} cnt_op_e;
  typedef enum logic [1:0] {O_NONE, O_OK, O_ERR} out_e;

  typedef struct packed {
    cond_e   cond;
    step_t   target;
    addr_e   addr;
    logic    we;
    waddr_e  waddr;
    wdata_e  wdata;
    cur_op_e cur_op;
    cnt_op_e cnt_op;
    out_e    out_sel;
  } uword_t;

  // datapath controls after condition gating
  typedef struct packed {
    addr_e      addr;
    logic       we;
    waddr_e     waddr;
    wdata_e     wdata;
    cur_op_e    cur_op;
    cnt_op_e    cnt_op;
    logic       st_wr;
    logic [1:0] st_val;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic [2:0] cmd;
    logic       idx_ok;
    logic       hops_zero;
    logic       rd_zero;
    logic       rd_end;
    logic       rd_usable;
    logic       cur_last;
    logic       cnt_limit;
    logic       seek_last;
  } flags_t;

  typedef struct packed {
    logic busy;
    logic emit_ok;
    logic emit_err;
  } seq_stat_t;

  function automatic uword_t mk(cond_e c, step_t t, addr_e a, logic we, waddr_e wa,
                                wdata_e wd, cur_op_e co, cnt_op_e no, out_e os);
    uword_t w;
    w.cond    = c;
    w.target  = t;
    w.addr    = a;
    w.we      = we;
    w.waddr   = wa;
    w.wdata   = wd;
    w.cur_op  = co;
    w.cnt_op  = no;
    w.out_sel = os;
    return w;
  endfunction

  // microcode program
  function automatic uword_t ucode(step_t pc);
    uword_t w;
    case (pc)
      STEP_IDLE:
        w = mk(C_WAIT, STEP_IDLE, A_CUR, 1'b0, W_CUR, D_ZERO, CUR_HOLD, CNT_HOLD, O_NONE);
      STEP_DISPATCH:
        w = mk(C_CMD, STEP_IDLE, A_IDX, 1'b0, W_CUR, D_ZERO, CUR_IDX, CNT_CLR, O_NONE);
      STEP_ALLOC_START:
        w = mk(C_NEXT, STEP_IDLE, A_ONE, 1'b0, W_CUR, D_ZERO, CUR_ONE, CNT_HOLD, O_NONE);
      STEP_SCAN:
        w = mk(C_SCAN, STEP_IDLE, A_CUR_INC, 1'b0, W_CUR, D_ZERO, CUR_INC, CNT_HOLD,
               O_NONE);
      STEP_SCAN_FOUND:
        w = mk(C_APPEND, STEP_EMIT_OK, A_CUR, 1'b1, W_CUR, D_END, CUR_HOLD, CNT_HOLD,
               O_NONE);
      STEP_APPEND_LINK:
        w = mk(C_NEXT, STEP_IDLE, A_CUR, 1'b1, W_IDX, D_CUR, CUR_HOLD, CNT_HOLD, O_NONE);
      STEP_EMIT_OK:
        w = mk(C_EMIT, STEP_IDLE, A_CUR, 1'b0, W_CUR, D_ZERO, CUR_HOLD, CNT_HOLD, O_OK);
      STEP_EMIT_ERR:
        w = mk(C_EMIT, STEP_IDLE, A_CUR, 1'b0, W_CUR, D_ZERO, CUR_HOLD, CNT_HOLD, O_ERR);
      STEP_SEEK:
        w = mk(C_SEEK, STEP_EMIT_OK, A_LINK, 1'b0, W_CUR, D_ZERO, CUR_LINK, CNT_INC,
               O_NONE);
      STEP_FIND_INIT:
        w = mk(C_NEXT, STEP_IDLE, A_CUR, 1'b0, W_CUR, D_ZERO, CUR_HOLD, CNT_ONE, O_NONE);
      STEP_FIND:
        w = mk(C_FIND, STEP_EMIT_OK, A_LINK, 1'b0, W_CUR, D_ZERO, CUR_LINK, CNT_INC,
               O_NONE);
      STEP_WRITE:
        w = mk(C_JUMP, STEP_EMIT_OK, A_CUR, 1'b1, W_CUR, D_VAL, CUR_HOLD, CNT_HOLD,
               O_NONE);
      STEP_CLEAR:
        w = mk(C_CLEAR, STEP_IDLE, A_CUR, 1'b1, W_CUR, D_ZERO, CUR_INC, CNT_HOLD, O_NONE);
      default:
        w = mk(C_JUMP, STEP_IDLE, A_CUR, 1'b0, W_CUR, D_ZERO, CUR_HOLD, CNT_HOLD, O_NONE);
    endcase
    return w;
  endfunction

  // first step of each command
  function automatic step_t dispatch(logic [2:0] cmd, logic idx_ok, logic hops_zero);
    step_t s;
    case (cmd)
      CMD_ALLOC:  s = STEP_ALLOC_START;
      CMD_APPEND: s = idx_ok ? STEP_ALLOC_START : STEP_EMIT_ERR;
      CMD_SEEK:   s = !idx_ok ? STEP_EMIT_ERR : (hops_zero ? STEP_EMIT_OK : STEP_SEEK);
      CMD_FIND:   s = idx_ok ? STEP_FIND_INIT : STEP_EMIT_ERR;
      CMD_WRITE:  s = idx_ok ? STEP_WRITE : STEP_EMIT_ERR;
      default:    s = STEP_EMIT_ERR;
    endcase
    return s;
  endfunction

endpackage

// ===== src/fce_sequencer.sv =====
// ----------------------------------------------------------------------------
// fce_sequencer
// Step counter, program lookup and jump conditions of the chain table engine.
// ----------------------------------------------------------------------------
module fce_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               out_free_i,
  input  fce_pkg::flags_t    flags_i,
  output fce_pkg::ctrl_t     ctrl_o,
  output fce_pkg::seq_stat_t stat_o
);

  fce_pkg::step_t  pc_q, pc_d;
  fce_pkg::uword_t word;
  logic            adv;
  logic            st_wr;
  logic [1:0]      st_val;

  assign word = fce_pkg::ucode(pc_q);

  always_comb begin
    pc_d   = pc_q + 4'd1;
    adv    = 1'b1;
    st_wr  = 1'b0;
    st_val = fce_pkg::ST_BAD;
    case (word.cond)
      fce_pkg::C_NEXT: pc_d = pc_q + 4'd1;
      fce_pkg::C_JUMP: pc_d = word.target;
      fce_pkg::C_WAIT: begin
        if (!accept_i) pc_d = pc_q;
      end
      fce_pkg::C_CMD: begin
        pc_d  = fce_pkg::dispatch(flags_i.cmd, flags_i.idx_ok, flags_i.hops_zero);
        st_wr = 1'b1;
      end
      fce_pkg::C_SCAN: begin
        adv = 1'b0;
        if (flags_i.rd_zero) begin
          pc_d = pc_q + 4'd1;
        end else if (flags_i.cur_last) begin
          pc_d   = fce_pkg::STEP_EMIT_ERR;
          st_wr  = 1'b1;
          st_val = fce_pkg::ST_FULL;
        end else begin
          pc_d = pc_q;
          adv  = 1'b1;
        end
      end
      fce_pkg::C_APPEND: begin
        if (flags_i.cmd != fce_pkg::CMD_APPEND) pc_d = word.target;
      end
      fce_pkg::C_SEEK: begin
        adv = 1'b0;
        if (flags_i.cnt_limit) begin
          pc_d   = fce_pkg::STEP_EMIT_ERR;
          st_wr  = 1'b1;
          st_val = fce_pkg::ST_LOOP;
        end else if (!flags_i.rd_usable) begin
          pc_d  = fce_pkg::STEP_EMIT_ERR;
          st_wr = 1'b1;
        end else begin
          adv  = 1'b1;
          pc_d = flags_i.seek_last ? word.target : pc_q;
        end
      end
      fce_pkg::C_FIND: begin
        adv = 1'b0;
        if (flags_i.rd_end) begin
          pc_d = word.target;
        end else if (!flags_i.rd_usable) begin
          pc_d  = fce_pkg::STEP_EMIT_ERR;
          st_wr = 1'b1;
        end else if (flags_i.cnt_limit) begin
          pc_d   = fce_pkg::STEP_EMIT_ERR;
          st_wr  = 1'b1;
          st_val = fce_pkg::ST_LOOP;
        end else begin
          pc_d = pc_q;
          adv  = 1'b1;
        end
      end
      fce_pkg::C_CLEAR: begin
        if (flags_i.cur_last) begin
          pc_d = word.target;
          adv  = 1'b0;
        end else begin
          pc_d = pc_q;
        end
      end
      fce_pkg::C_EMIT: begin
        pc_d = out_free_i ? word.target : pc_q;
      end
      default: pc_d = fce_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= fce_pkg::STEP_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_comb begin
    ctrl_o.addr   = word.addr;
    ctrl_o.we     = word.we;
    ctrl_o.waddr  = word.waddr;
    ctrl_o.wdata  = word.wdata;
    ctrl_o.cur_op = adv ? word.cur_op : fce_pkg::CUR_HOLD;
    ctrl_o.cnt_op = adv ? word.cnt_op : fce_pkg::CNT_HOLD;
    ctrl_o.st_wr  = st_wr;
    ctrl_o.st_val = st_val;
  end

  assign stat_o.busy     = (pc_q != fce_pkg::STEP_IDLE);
  assign stat_o.emit_ok  = (word.out_sel == fce_pkg::O_OK) && out_free_i;
  assign stat_o.emit_err = (word.out_sel == fce_pkg::O_ERR) && out_free_i;

endmodule

// ===== src/fce_datapath.sv =====
// ----------------------------------------------------------------------------
// fce_datapath
// Table memory, command registers, block pointer, hop counter and status.
// ----------------------------------------------------------------------------
module fce_datapath #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic [2:0]      command_i,
  input  logic [9:0]      block_index_i,
  input  logic [9:0]      hop_count_i,
  input  logic [31:0]     entry_value_i,
  input  fce_pkg::ctrl_t  ctrl_i,
  output fce_pkg::flags_t flags_o,
  output logic [9:0]      cur_block_o,
  output logic [10:0]     count_o,
  output logic [1:0]      err_status_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = IdxW;

  logic [31:0]     mem_q [TABLE_ENTRIES];
  logic [31:0]     rdata_q;
  logic [2:0]      cmd_q;
  logic [9:0]      idx_q;
  logic [9:0]      hops_q;
  logic [31:0]     val_q;
  logic [IdxW-1:0] cur_q, cur_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      st_q, st_d;
  logic [IdxW-1:0] raddr, waddr, link;
  logic [31:0]     wdata;

  assign link = rdata_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cmd_q  <= command_i;
      idx_q  <= block_index_i;
      hops_q <= hop_count_i;
      val_q  <= entry_value_i;
    end
  end

  always_comb begin
    case (ctrl_i.addr)
      fce_pkg::A_CUR:     raddr = cur_q;
      fce_pkg::A_CUR_INC: raddr = IdxW'(cur_q + 1'b1);
      fce_pkg::A_IDX:     raddr = IdxW'(idx_q);
      fce_pkg::A_LINK:    raddr = link;
      fce_pkg::A_ONE:     raddr = IdxW'(1);
      default:            raddr = cur_q;
    endcase
    waddr = (ctrl_i.waddr == fce_pkg::W_IDX) ? IdxW'(idx_q) : cur_q;
    case (ctrl_i.wdata)
      fce_pkg::D_ZERO: wdata = '0;
      fce_pkg::D_END:  wdata = fce_pkg::END_MARK;
      fce_pkg::D_VAL:  wdata = val_q;
      fce_pkg::D_CUR:  wdata = 32'(cur_q);
      default:         wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  always_comb begin
    case (ctrl_i.cur_op)
      fce_pkg::CUR_HOLD: cur_d = cur_q;
      fce_pkg::CUR_IDX:  cur_d = IdxW'(idx_q);
      fce_pkg::CUR_ONE:  cur_d = IdxW'(1);
      fce_pkg::CUR_INC:  cur_d = IdxW'(cur_q + 1'b1);
      fce_pkg::CUR_LINK: cur_d = link;
      default:           cur_d = cur_q;
    endcase
    case (ctrl_i.cnt_op)
      fce_pkg::CNT_HOLD: cnt_d = cnt_q;
      fce_pkg::CNT_CLR:  cnt_d = '0;
      fce_pkg::CNT_ONE:  cnt_d = CntW'(1);
      fce_pkg::CNT_INC:  cnt_d = CntW'(cnt_q + 1'b1);
      default:           cnt_d = cnt_q;
    endcase
    st_d = ctrl_i.st_wr ? ctrl_i.st_val : st_q;
  end

  // cur starts at zero so the clearing pass after reset sweeps the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      cnt_q <= '0;
      st_q  <= fce_pkg::ST_OK;
    end else begin
      cur_q <= cur_d;
      cnt_q <= cnt_d;
      st_q  <= st_d;
    end
  end

  always_comb begin
    flags_o.cmd       = cmd_q;
    flags_o.idx_ok    = (idx_q != '0) && (32'(idx_q) < 32'(TABLE_ENTRIES));
    flags_o.hops_zero = (hops_q == '0);
    flags_o.rd_zero   = (rdata_q == '0);
    flags_o.rd_end    = (rdata_q == fce_pkg::END_MARK);
    flags_o.rd_usable = (rdata_q != '0) && (rdata_q < 32'(TABLE_ENTRIES));
    flags_o.cur_last  = (cur_q == IdxW'(TABLE_ENTRIES - 1));
    flags_o.cnt_limit = (32'(cnt_q) >= 32'(TABLE_ENTRIES - 1));
    flags_o.seek_last = (32'(cnt_q) + 32'd1 == 32'(hops_q));
  end

  assign cur_block_o  = 10'(cur_q);
  assign count_o      = 11'(cnt_q);
  assign err_status_o = st_q;

endmodule

// ===== src/fat_chain_table_engine.sv =====
// ----------------------------------------------------------------------------
// fat_chain_table_engine
// Allocation table of chained blocks with allocate, append, seek, find-last
// and write commands, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// One item at a time. The table is a memory with one read and one write
// port, read one entry per cycle. Each command runs its own steps before
// the result is registered, with one read per entry looked at: allocate and
// append scan up to the first free entry (at most TABLE_ENTRIES-1), seek
// reads one entry per hop, find-last one per block in the chain. An index or
// command rejected at once goes straight from dispatch to its result. The
// engine then returns to idle before it takes the next item, and a stalled
// result holds it in its last step. After reset the table is swept to zero,
// during which in_stall_o stays high. A new item is taken while the previous
// result still waits in the output register.
module fat_chain_table_engine #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [9:0]  block_index_i,
  input  logic [9:0]  hop_count_i,
  input  logic [31:0] entry_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  result_block_o,
  output logic [10:0] chain_length_o,
  output logic [1:0]  status_o
);

  fce_pkg::ctrl_t     ctrl;
  fce_pkg::flags_t    flags;
  fce_pkg::seq_stat_t stat;
  logic               accept;
  logic               out_free;
  logic [9:0]         cur_block;
  logic [10:0]        count;
  logic [1:0]         err_status;
  logic               out_valid_q;
  logic [9:0]         result_block_q;
  logic [10:0]        chain_length_q;
  logic [1:0]         status_q;

  assign in_stall_o = stat.busy;
  assign accept     = in_valid_i && !stat.busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  fce_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .out_free_i (out_free),
    .flags_i    (flags),
    .ctrl_o     (ctrl),
    .stat_o     (stat)
  );

  fce_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .command_i     (command_i),
    .block_index_i (block_index_i),
    .hop_count_i   (hop_count_i),
    .entry_value_i (entry_value_i),
    .ctrl_i        (ctrl),
    .flags_o       (flags),
    .cur_block_o   (cur_block),
    .count_o       (count),
    .err_status_o  (err_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.emit_ok || stat.emit_err) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.emit_ok) begin
      result_block_q <= cur_block;
      chain_length_q <= count;
      status_q       <= fce_pkg::ST_OK;
    end else if (stat.emit_err) begin
      result_block_q <= '0;
      chain_length_q <= count;
      status_q       <= err_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_block_o = result_block_q;
  assign chain_length_o = chain_length_q;
  assign status_o       = status_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("engine not busy after taking an item");

  a_err_block_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != fce_pkg::ST_OK |-> result_block_o == '0)
    else $error("error result carries a block index");

  a_full_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == fce_pkg::ST_FULL |-> chain_length_o == '0)
    else $error("table full result carries a length");

endmodule

// ===== test/fat_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fat_result_checker
// Watches both channels of the chain table engine. It keeps its own copy of
// the allocation table, works out each result when an item is accepted, and
// compares every result that leaves the block with the oldest one awaited.
// ----------------------------------------------------------------------------
module fat_result_checker #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [2:0]       command_i,
  input  logic [9:0]       block_index_i,
  input  logic [9:0]       hop_count_i,
  input  logic [31:0]      entry_value_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [9:0]       result_block_i,
  input  logic [10:0]      chain_length_i,
  input  logic [1:0]       status_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      results_o,
  output logic [3:0][15:0] status_seen_o
);

  typedef struct packed {
    logic [9:0]  blk;
    logic [10:0] len;
    logic [1:0]  st;
  } fat_result_t;

  logic [31:0]      fat_mirror [TABLE_ENTRIES];
  fat_result_t      awaited_results [$];
  int unsigned      fails;
  int unsigned      outstanding;
  int unsigned      checked;
  logic [3:0][15:0] status_seen;

  // a usable block: neither the reserved entry nor past the end of the table
  function automatic logic link_ok(logic [31:0] v);
    return v != 32'd0 && v < 32'(TABLE_ENTRIES);
  endfunction

  function automatic fat_result_t predict_command(logic [2:0] cmd, logic [9:0] idx,
                                                  logic [9:0] hops, logic [31:0] val);
    fat_result_t r;
    int unsigned i;
    int unsigned cur;
    int unsigned fresh;
    int unsigned n;
    logic [31:0] nxt;
    logic        done;
    r = '0;
    r.st = fce_pkg::ST_BAD;
    case (cmd)
      fce_pkg::CMD_ALLOC, fce_pkg::CMD_APPEND: begin
        if (cmd == fce_pkg::CMD_ALLOC || link_ok({22'd0, idx})) begin
          fresh = 0;
          for (i = 1; i < TABLE_ENTRIES && fresh == 0; i++) begin
            if (fat_mirror[i] == 32'd0) fresh = i;
          end
          if (fresh == 0) begin
            r.st = fce_pkg::ST_FULL;
          end else begin
            fat_mirror[fresh] = fce_pkg::END_MARK;
            // a free tail picked by the scan ends up linked to itself
            if (cmd == fce_pkg::CMD_APPEND) fat_mirror[idx] = fresh;
            r.blk = 10'(fresh);
            r.st = fce_pkg::ST_OK;
          end
        end
      end
      fce_pkg::CMD_SEEK: if (link_ok({22'd0, idx})) begin
        cur = 32'(idx);
        n = 0;
        done = 1'b0;
        r.st = fce_pkg::ST_OK;
        while (!done && n < hops) begin
          nxt = fat_mirror[cur];
          if (n >= TABLE_ENTRIES - 1) begin
            r.st = fce_pkg::ST_LOOP;
            done = 1'b1;
          end else if (nxt == fce_pkg::END_MARK || !link_ok(nxt)) begin
            r.st = fce_pkg::ST_BAD;
            done = 1'b1;
          end else begin
            cur = nxt;
            n++;
          end
        end
        r.len = 11'(n);
        if (r.st == fce_pkg::ST_OK) r.blk = 10'(cur);
      end
      fce_pkg::CMD_FIND: if (link_ok({22'd0, idx})) begin
        cur = 32'(idx);
        n = 1;
        done = 1'b0;
        while (!done) begin
          nxt = fat_mirror[cur];
          if (nxt == fce_pkg::END_MARK) begin
            r.st = fce_pkg::ST_OK;
            r.blk = 10'(cur);
            done = 1'b1;
          end else if (!link_ok(nxt)) begin
            r.st = fce_pkg::ST_BAD;
            done = 1'b1;
          end else if (n >= TABLE_ENTRIES - 1) begin
            r.st = fce_pkg::ST_LOOP;
            done = 1'b1;
          end else begin
            cur = nxt;
            n++;
          end
        end
        r.len = 11'(n);
      end
      fce_pkg::CMD_WRITE: if (link_ok({22'd0, idx})) begin
        fat_mirror[idx] = val;
        r.blk = idx;
        r.st = fce_pkg::ST_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int unsigned k;
    fat_result_t want;
    fat_result_t got;
    if (!rst_ni) begin
      for (k = 0; k < TABLE_ENTRIES; k++) fat_mirror[k] = 32'd0;
      awaited_results.delete();
      fails = 0;
      outstanding = 0;
      checked = 0;
      status_seen = '0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(predict_command(command_i, block_index_i, hop_count_i,
                                                  entry_value_i));
        outstanding++;
      end
      if (out_valid_i && !out_stall_i) begin
        got = {result_block_i, chain_length_i, status_i};
        checked++;
        status_seen[status_i] = status_seen[status_i] + 16'd1;
        if (outstanding == 0) begin
          fails++;
          $display("%0t: expected no result, got block %0d length %0d status %0d", $time,
                   got.blk, got.len, got.st);
        end else begin
          want = awaited_results.pop_front();
          outstanding--;
          if (got.blk !== want.blk || got.len !== want.len || got.st !== want.st) begin
            fails++;
            $display("%0t: expected block %0d length %0d status %0d, got block %0d length %0d status %0d",
                     $time, want.blk, want.len, want.st, got.blk, got.len, got.st);
          end
        end
      end
    end
    fail_count_o  <= fails;
    pending_o     <= outstanding;
    results_o     <= checked;
    status_seen_o <= status_seen;
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the chain table engine with corner cases, random chains, loops,
// noise and a completely filled table, with bursty input and a stalling
// output side; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int          CMD_CODES     = 8;
  localparam int unsigned RANDOM_ITEMS  = 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 1100;
  localparam int unsigned MAX_CHAIN     = 24;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  command_i;
  logic [9:0]  block_index_i;
  logic [9:0]  hop_count_i;
  logic [31:0] entry_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [9:0]  result_block_o;
  logic [10:0] chain_length_o;
  logic [1:0]  status_o;

  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      results;
  logic [3:0][15:0] status_seen;

  int unsigned items       = 0;
  int unsigned burst_left  = 0;
  logic        steady      = 1'b0;
  logic        rand_phase  = 1'b0;
  logic        held_once   = 1'b0;

  fat_chain_table_engine #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .block_index_i (block_index_i),
    .hop_count_i   (hop_count_i),
    .entry_value_i (entry_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_block_o(result_block_o),
    .chain_length_o(chain_length_o),
    .status_o      (status_o)
  );

  fat_result_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) results_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .command_i     (command_i),
    .block_index_i (block_index_i),
    .hop_count_i   (hop_count_i),
    .entry_value_i (entry_value_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_block_i(result_block_o),
    .chain_length_i(chain_length_o),
    .status_i      (status_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_o     (results),
    .status_seen_o (status_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // worst case is about 650 items of a full table walk each, taken several times
  initial begin
    #30_000_000;
    $display("testbench failed");
    $finish;
  end

  // output side: stretches of different stall density, plus one long hold-off
  initial begin : receiver
    int unsigned stretch;
    int unsigned pct;
    out_stall_i <= 1'b0;
    forever begin
      stretch = $urandom_range(16, 160);
      case ($urandom_range(3))
        0: pct = 0;
        1: pct = 20;
        2: pct = 50;
        default: pct = 85;
      endcase
      repeat (stretch) begin
        @(posedge clk_i);
        if (!held_once && rand_phase && out_valid_o) begin
          held_once = 1'b1;
          out_stall_i <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        out_stall_i <= ($urandom_range(99) < pct);
      end
    end
  end

  task automatic offer(input logic [2:0] cmd, input logic [9:0] idx, input logic [9:0] hops,
                       input logic [31:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    block_index_i <= idx;
    hop_count_i   <= hops;
    entry_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    items++;
  endtask

  // hold the input until every awaited result has left the block
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    burst_left = 0;
  endtask

  initial begin : stimulus
    logic [9:0]  links [MAX_CHAIN];
    int unsigned len;
    int unsigned k;
    int unsigned episode;
    int unsigned first_random;
    int          c;
    logic [9:0]  idx;
    logic [31:0] val;
    in_valid_i    <= 1'b0;
    command_i     <= fce_pkg::CMD_ALLOC;
    block_index_i <= '0;
    hop_count_i   <= '0;
    entry_value_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short chain 1 -> 2 -> 3 built by allocate and append
    offer(fce_pkg::CMD_ALLOC, 10'd0, 10'd0, 32'd0);
    offer(fce_pkg::CMD_APPEND, 10'd1, 10'd0, 32'd0);
    offer(fce_pkg::CMD_APPEND, 10'd2, 10'd0, 32'd0);
    offer(fce_pkg::CMD_FIND, 10'd1, 10'd0, 32'd0);
    offer(fce_pkg::CMD_SEEK, 10'd1, 10'd2, 32'd0);
    offer(fce_pkg::CMD_SEEK, 10'd1, 10'd0, 32'd0);
    offer(fce_pkg::CMD_SEEK, 10'd1, 10'd5, 32'd0);
    // reserved entry as index
    offer(fce_pkg::CMD_FIND, 10'd0, 10'd0, 32'd0);
    offer(fce_pkg::CMD_WRITE, 10'd0, 10'd0, fce_pkg::END_MARK);
    offer(fce_pkg::CMD_APPEND, 10'd0, 10'd0, 32'd0);
    offer(fce_pkg::CMD_SEEK, 10'd0, 10'h3FF, 32'd0);
    for (c = int'(fce_pkg::CMD_WRITE) + 1; c < CMD_CODES; c++)
      offer(3'(c), 10'd5, 10'd1, 32'd0);
    offer(fce_pkg::CMD_FIND, 10'd500, 10'd0, 32'd0);
    // links into a free entry and past the table
    offer(fce_pkg::CMD_WRITE, 10'd10, 10'd0, 32'd1023);
    offer(fce_pkg::CMD_FIND, 10'd10, 10'd0, 32'd0);
    offer(fce_pkg::CMD_WRITE, 10'd11, 10'd0, 32'h0000_0400);
    offer(fce_pkg::CMD_FIND, 10'd11, 10'd0, 32'd0);
    // two-block loop
    offer(fce_pkg::CMD_WRITE, 10'd20, 10'd0, 32'd21);
    offer(fce_pkg::CMD_WRITE, 10'd21, 10'd0, 32'd20);
    offer(fce_pkg::CMD_FIND, 10'd20, 10'd0, 32'd0);
    offer(fce_pkg::CMD_SEEK, 10'd20, 10'h3FF, 32'd0);
    // free tail that the scan picks for itself
    offer(fce_pkg::CMD_APPEND, 10'd4, 10'd0, 32'd0);
    offer(fce_pkg::CMD_FIND, 10'd4, 10'd0, 32'd0);
    offer(fce_pkg::CMD_WRITE, 10'd1023, 10'd0, fce_pkg::END_MARK);
    offer(fce_pkg::CMD_SEEK, 10'd10, 10'd1, 32'd0);

    rand_phase = 1'b1;
    first_random = items;
    episode = 0;
    while (items - first_random < RANDOM_ITEMS) begin
      episode++;
      steady = ($urandom_range(7) == 0);
      if (episode % 4 == 0) drain();
      case ($urandom_range(9))
        6, 7: begin
          repeat ($urandom_range(5, 15)) begin
            case ($urandom_range(5))
              0: idx = 10'd0;
              1: idx = 10'h3FF;
              default: idx = 10'($urandom_range(1, TABLE_ENTRIES - 1));
            endcase
            case ($urandom_range(3))
              0: val = 32'd0;
              1: val = fce_pkg::END_MARK;
              2: val = $urandom_range(0, TABLE_ENTRIES + 8);
              default: val = $urandom;
            endcase
            offer(3'($urandom_range(CMD_CODES - 1)), idx, 10'($urandom), val);
          end
        end
        8: begin
          // small loop: the last link points back into the chain
          len = $urandom_range(1, 6);
          for (k = 0; k < len; k++) links[k] = 10'($urandom_range(1, TABLE_ENTRIES - 1));
          for (k = 0; k < len; k++)
            offer(fce_pkg::CMD_WRITE, links[k], 10'($urandom),
                  {22'd0, (k == len - 1) ? links[$urandom_range(len - 1)] : links[k + 1]});
          offer(fce_pkg::CMD_FIND, links[0], 10'($urandom), $urandom);
          offer(fce_pkg::CMD_SEEK, links[0], 10'($urandom), $urandom);
        end
        9: begin
          repeat ($urandom_range(1, 6))
            offer(fce_pkg::CMD_ALLOC, 10'($urandom), 10'($urandom), $urandom);
        end
        default: begin
          len = ($urandom_range(15) == 0) ? $urandom_range(12, MAX_CHAIN) :
                                            $urandom_range(1, 10);
          for (k = 0; k < len; k++) links[k] = 10'($urandom_range(1, TABLE_ENTRIES - 1));
          for (k = 0; k < len; k++)
            offer(fce_pkg::CMD_WRITE, links[k], 10'($urandom),
                  (k == len - 1) ? fce_pkg::END_MARK : {22'd0, links[k + 1]});
          repeat ($urandom_range(2, 8)) begin
            case ($urandom_range(5))
              0: offer(fce_pkg::CMD_FIND, links[0], 10'($urandom), $urandom);
              1: offer(fce_pkg::CMD_SEEK, links[0], 10'($urandom_range(0, len + 1)),
                       $urandom);
              2: offer(fce_pkg::CMD_APPEND, links[len - 1], 10'($urandom), $urandom);
              3: offer(fce_pkg::CMD_ALLOC, 10'($urandom), 10'($urandom), $urandom);
              4: offer(fce_pkg::CMD_SEEK, links[$urandom_range(len - 1)],
                       10'($urandom_range(0, len)), $urandom);
              default: begin
                // cut or free one link of the chain
                offer(fce_pkg::CMD_WRITE, links[$urandom_range(len - 1)], 10'($urandom),
                      $urandom_range(1) ? fce_pkg::END_MARK : 32'd0);
              end
            endcase
          end
        end
      endcase
    end
    rand_phase = 1'b0;
    steady = 1'b0;
    drain();

    // appends onto tails from the top down fill the lowest free entry and the
    // tail at once, so the upper half of tails leaves the table full
    for (k = TABLE_ENTRIES - 1; k >= TABLE_ENTRIES / 2; k--)
      offer(fce_pkg::CMD_APPEND, 10'(k), 10'($urandom), $urandom);
    offer(fce_pkg::CMD_ALLOC, 10'd0, 10'd0, 32'd0);
    offer(fce_pkg::CMD_APPEND, 10'd7, 10'd0, 32'd0);
    offer(fce_pkg::CMD_WRITE, 10'd600, 10'd0, 32'd0);
    offer(fce_pkg::CMD_APPEND, 10'd1023, 10'd0, 32'd0);
    offer(fce_pkg::CMD_ALLOC, 10'd0, 10'd0, 32'd0);
    offer(fce_pkg::CMD_FIND, 10'd1023, 10'd0, 32'd0);
    offer(fce_pkg::CMD_SEEK, 10'd1023, 10'd1, 32'd0);
    // a block linked to itself: find-last walks until the loop limit, seek until its hop count
    offer(fce_pkg::CMD_WRITE, 10'd1023, 10'd0, 32'd1023);
    offer(fce_pkg::CMD_FIND, 10'd1023, 10'd0, 32'd0);
    offer(fce_pkg::CMD_SEEK, 10'd1023, 10'h3FF, 32'd0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d items: corner cases, random chains and loops, noise, a full table",
             items);
    $display("checked %0d results: %0d ok, %0d full, %0d bad index or link, %0d loop",
             results, status_seen[fce_pkg::ST_OK], status_seen[fce_pkg::ST_FULL],
             status_seen[fce_pkg::ST_BAD], status_seen[fce_pkg::ST_LOOP]);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
